[sv/sorted_key_table_insert_lookup_defines.svh]
// ---------------------------------------------------------------------------
// sorted key table assertion macros
// shared concurrent assertion forms, sampled on clock, disabled in reset
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_INSERT_LOOKUP_DEFINES_SVH
`define SORTED_KEY_TABLE_INSERT_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SKT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/skt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_pkg
// types, sizes and codes shared by the sorted key table modules
// ---------------------------------------------------------------------------
package skt_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W       = 7;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 88;

   typedef enum logic [2:0] {
      STAT_INSERTED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } command_type;

   // stored record, key in the low bits (same order as the request data)
   typedef struct packed {
      logic [23:0] unit_price_cents;
      logic [11:0] sale_year;
      logic [3:0]  sale_month;
      logic [4:0]  sale_day;
      logic [15:0] pieces_sold;
      logic [15:0] article_id;
      logic [15:0] sale_key;
   } record_type;

   localparam int REC_W = $bits(record_type);

   typedef struct packed {
      logic [23:0]      out_price;
      logic [11:0]      out_year;
      logic [3:0]       out_month;
      logic [4:0]       out_day;
      logic [15:0]      out_pieces;
      logic [15:0]      out_article;
      logic [POS_W-1:0] position;
   } rsp_data_type;

   typedef struct packed {
      status_type   status;
      rsp_data_type data;
   } result_type;

   // control group from sequencer to record memory
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      record_type       wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

[sv/skt_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_ram
// simple dual-port synchronous ram, one write and one registered read
// ---------------------------------------------------------------------------
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/skt_ctrl.sv]
`timescale 1ns / 1ps
`include "sorted_key_table_insert_lookup_defines.svh"
// ---------------------------------------------------------------------------
// skt_ctrl
// command sequencer: append check, binary search, shift-up and fill
// ---------------------------------------------------------------------------
module skt_ctrl
   import skt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  command_type req_cmd,
   input  record_type  req_rec,
   output ram_req_type ram_req,
   input  record_type  ram_rd_data,
   output logic        res_valid,
   input  logic        res_ready,
   output result_type  res
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DISPATCH = 8'b0000_0010,
      S_LAST_CHK = 8'b0000_0100,
      S_SRCH_RD  = 8'b0000_1000,
      S_SRCH_CHK = 8'b0001_0000,
      S_SHIFT    = 8'b0010_0000,
      S_FILL     = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   command_type      cmd_ff, cmd_in;
   record_type       rec_ff, rec_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             issue_done_ff, issue_done_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   result_type       res_ff, res_in;

   always_comb begin
      logic [CNT_W-1:0] mid_wide;
      logic [CNT_W-1:0] last_idx;

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rec_in        = rec_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_in        = res_ff;
      ram_req       = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      mid_wide      = lo_ff + ((hi_ff - lo_ff) >> 1);
      last_idx      = cnt_ff - CNT_W'(1);

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_cmd;
               rec_in   = req_rec;
               res_in   = '0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            lo_in = '0;
            hi_in = cnt_ff;
            if (cmd_ff == CMD_INSERT) begin
               if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
                  res_in.status = STAT_FULL;
                  state_in      = S_DONE;
               end else if (cnt_ff == '0) begin
                  slot_in  = '0;
                  state_in = S_FILL;
               end else begin
                  // fetch the last entry for the append check
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = last_idx[IDX_W-1:0];
                  state_in        = S_LAST_CHK;
               end
            end else if (cnt_ff == '0) begin
               res_in.status = STAT_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_LAST_CHK: begin
            if (rec_ff.sale_key > ram_rd_data.sale_key) begin
               slot_in  = cnt_ff[IDX_W-1:0];
               state_in = S_FILL;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in          = mid_wide[IDX_W-1:0];
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid_wide[IDX_W-1:0];
               state_in        = S_SRCH_CHK;
            end else if (cmd_ff == CMD_LOOKUP) begin
               res_in.status = STAT_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               // key absent, lo is the insertion point
               slot_in       = lo_ff[IDX_W-1:0];
               idx_in        = last_idx[IDX_W-1:0];
               issue_done_in = 1'b0;
               state_in      = (lo_ff == cnt_ff) ? S_FILL : S_SHIFT;
            end
         end
         S_SRCH_CHK: begin
            if (ram_rd_data.sale_key == rec_ff.sale_key) begin
               if (cmd_ff == CMD_INSERT) begin
                  res_in.status = STAT_DUPLICATE;
               end else begin
                  res_in.status           = STAT_FOUND;
                  res_in.data.position    = POS_W'(mid_ff);
                  res_in.data.out_article = ram_rd_data.article_id;
                  res_in.data.out_pieces  = ram_rd_data.pieces_sold;
                  res_in.data.out_day     = ram_rd_data.sale_day;
                  res_in.data.out_month   = ram_rd_data.sale_month;
                  res_in.data.out_year    = ram_rd_data.sale_year;
                  res_in.data.out_price   = ram_rd_data.unit_price_cents;
               end
               state_in = S_DONE;
            end else begin
               if (ram_rd_data.sale_key < rec_ff.sale_key) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_in = CNT_W'(mid_ff);
               end
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT: begin
            // write back the entry read last cycle one slot higher
            if (pend_valid_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = pend_addr_ff;
               ram_req.wr_data = ram_rd_data;
            end
            if (issue_done_ff) begin
               state_in = S_FILL;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_ff;
               pend_valid_in   = 1'b1;
               pend_addr_in    = idx_ff + IDX_W'(1);
               if (idx_ff == slot_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         S_FILL: begin
            ram_req.wr_en        = 1'b1;
            ram_req.wr_addr      = slot_ff;
            ram_req.wr_data      = rec_ff;
            cnt_in               = cnt_ff + CNT_W'(1);
            res_in.status        = STAT_INSERTED;
            res_in.data.position = POS_W'(slot_ff);
            state_in             = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         issue_done_ff <= issue_done_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      rec_ff       <= rec_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
   end

   assign res = res_ff;

   `SKT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(TABLE_DEPTH), "entry count above depth")
   `SKT_ASSERT_SAME(a_wr_state, ram_req.wr_en, state_ff == S_SHIFT || state_ff == S_FILL, "stray ram write")
   `SKT_ASSERT_NEXT(a_fill_cnt, state_ff == S_FILL, cnt_ff == CNT_W'($past(cnt_ff) + 1'b1), "count not bumped")
   `SKT_ASSERT_SAME(a_shift_addr, pend_valid_ff, pend_addr_ff > slot_ff, "shift write below gap")

endmodule

[sv/sorted_key_table_insert_lookup.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_key_table_insert_lookup
// sorted record table with insert and binary-search lookup
// ---------------------------------------------------------------------------
// Holds up to TABLE_DEPTH (128) records in ascending key order in one
// single-write, single-read ram with a registered read. Each transaction
// is worked on alone by a sequencer: an insert into an empty table or
// above the last key writes the record into the next free slot, a
// lookup or duplicate ends after a binary search, and an insert into
// the middle searches, moves every entry at or above the insertion point
// up one slot (up to 127 entries) and then fills the gap. The shift rate
// is set by the ram's single write port, the search by its read latency.
// The response sits in an output register, so the next command is taken
// while the previous response waits. Ram contents need no clearing after
// reset: only entries below the entry count are ever read.
// ---------------------------------------------------------------------------
module sorted_key_table_insert_lookup
   import skt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = sale_key, article_id, pieces_sold, sale_day,
   //          sale_month, sale_year, unit_price_cents, zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]             req_tuser,    // command
   // response: tdata = position, out_article, out_pieces, out_day,
   //           out_month, out_year, out_price, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]             rsp_tuser     // status
);

   ram_req_type  ram_req;
   logic [REC_W-1:0] ram_rd_raw;
   logic         res_valid;
   logic         res_ready;
   result_type   res;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_ff, rsp_in;

   skt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (command_type'(req_tuser[0])),
      .req_rec     (record_type'(req_tdata[REC_W-1:0])),
      .ram_req     (ram_req),
      .ram_rd_data (record_type'(ram_rd_raw)),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   skt_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_raw)
   );

   // a finished result loads when the register is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {(RSP_TDATA_W - $bits(rsp_data_type))'(0), rsp_ff.data};

endmodule
